>>> hw/rtl/chip8ie_pkg.sv
// chip8ie_pkg: shared types and codes of the chip-8 execute block
// no dependencies
package chip8ie_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_COLS = 64;
  localparam int SCREEN_ROWS = 32;
  localparam int KEY_COUNT = 16;

  localparam logic [11:0] PC_RESET = 12'd512;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_ROW   = 2'd3;

  localparam logic [3:0] CL_WRITE = 4'd0;
  localparam logic [3:0] CL_READ  = 4'd1;
  localparam logic [3:0] CL_ROW   = 4'd2;
  localparam logic [3:0] CL_CLS   = 4'd3;
  localparam logic [3:0] CL_RET   = 4'd4;
  localparam logic [3:0] CL_JP    = 4'd5;
  localparam logic [3:0] CL_CALL  = 4'd6;
  localparam logic [3:0] CL_SKIP  = 4'd7;
  localparam logic [3:0] CL_LOAD  = 4'd8;
  localparam logic [3:0] CL_ALU   = 4'd9;
  localparam logic [3:0] CL_SETI  = 4'd10;
  localparam logic [3:0] CL_JPV0  = 4'd11;
  localparam logic [3:0] CL_DRAW  = 4'd12;
  localparam logic [3:0] CL_KEY   = 4'd13;
  localparam logic [3:0] CL_MISC  = 4'd14;
  localparam logic [3:0] CL_BAD   = 4'd15;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_SETI = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KK_CLS  = 8'hE0;
  localparam logic [7:0] KK_RET  = 8'hEE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_LDDT = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  typedef struct packed {
    logic [3:0]  cls;
    logic [15:0] opcode;
    logic [11:0] address;
    logic [7:0]  write_byte;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
  } item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [63:0] read_value;
    logic        display_changed;
    logic        waiting_for_key;
    logic        unknown_opcode;
    logic        draw_aborted;
    logic        sound_active;
  } res_t;

endpackage

>>> hw/rtl/chip8ie_front.sv
// chip8ie_front: accepts items, classifies them, holds them in a short queue
// depends on chip8ie_pkg
module chip8ie_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command,
  input  logic [15:0]         opcode,
  input  logic [11:0]         address,
  input  logic [7:0]          write_byte,
  input  logic [15:0]         keys_down,
  input  logic [7:0]          random_byte,
  output logic                q_valid,
  output chip8ie_pkg::item_t  q_item,
  input  logic                q_pop
);
  import chip8ie_pkg::*;

  item_t      slots [2];
  logic       wp, rp;
  logic [1:0] count;
  logic [3:0] cls;
  logic       do_push, do_pop;

  always_comb begin
    cls = CL_BAD;
    unique case (command)
      CMD_WRITE: cls = CL_WRITE;
      CMD_READ:  cls = CL_READ;
      CMD_ROW:   cls = CL_ROW;
      default: begin
        unique case (opcode[15:12])
          GRP_SYS: begin
            if (opcode[7:0] == KK_CLS) cls = CL_CLS;
            else if (opcode[7:0] == KK_RET) cls = CL_RET;
            else cls = CL_BAD;
          end
          GRP_JP:   cls = CL_JP;
          GRP_CALL: cls = CL_CALL;
          GRP_SE, GRP_SNE, GRP_SER, GRP_SNER: cls = CL_SKIP;
          GRP_LD, GRP_ADD, GRP_RND: cls = CL_LOAD;
          GRP_ALU:  cls = CL_ALU;
          GRP_SETI: cls = CL_SETI;
          GRP_JPV0: cls = CL_JPV0;
          GRP_DRW:  cls = CL_DRAW;
          GRP_KEY: begin
            if (opcode[7:0] == KK_SKP || opcode[7:0] == KK_SKNP) cls = CL_KEY;
            else cls = CL_BAD;
          end
          default: begin
            case (opcode[7:0])
              KK_LDDT, KK_WKEY, KK_SDT, KK_SST, KK_ADDI, KK_FONT, KK_BCD, KK_STR,
              KK_LDR: cls = CL_MISC;
              default: cls = CL_BAD;
            endcase
          end
        endcase
      end
    endcase
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= '{cls: cls, opcode: opcode, address: address, write_byte: write_byte,
                     keys_down: keys_down, random_byte: random_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> hw/rtl/chip8ie_back.sv
// chip8ie_back: sequencer that carries out queued items against the state
// and memories, and holds the finished result; depends on chip8ie_pkg
module chip8ie_back #(
  parameter int STACK_DEPTH = chip8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                bump,
  input  logic                q_valid,
  input  chip8ie_pkg::item_t  q_item,
  output logic                q_pop,
  output chip8ie_pkg::res_t   res,
  output logic                empty,
  input  logic                pop
);
  import chip8ie_pkg::*;

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SW-1:0] SP_LAST = SW'(STACK_DEPTH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_WB   = 4'd2;
  localparam logic [3:0] S_RET  = 4'd3;
  localparam logic [3:0] S_BCD1 = 4'd4;
  localparam logic [3:0] S_BCD2 = 4'd5;
  localparam logic [3:0] S_STR  = 4'd6;
  localparam logic [3:0] S_STW  = 4'd7;
  localparam logic [3:0] S_LDR  = 4'd8;
  localparam logic [3:0] S_LDW  = 4'd9;
  localparam logic [3:0] S_DRM  = 4'd10;
  localparam logic [3:0] S_DRR  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // stores
  logic [7:0]  regs [16];
  logic [15:0] rvalid;
  logic [7:0]  rda, rdb;
  logic [7:0]  mem [4096];
  logic [7:0]  mem_q;
  logic [11:0] stk [STACK_DEPTH];
  logic [11:0] stk_q;
  logic [63:0] frame [SCREEN_ROWS];
  logic [SCREEN_ROWS-1:0] fvalid;
  logic [63:0] fr_q;
  logic        fr_vq;

  // state
  logic [3:0]  state, state_next;
  item_t       cur, cur_next;
  logic [11:0] pc, pc_next, idx, idx_next;
  logic [SW-1:0] sp, sp_next;
  logic [7:0]  dly, dly_next, snd, snd_next;
  logic [3:0]  cnt, cnt_next;
  logic [7:0]  px, px_next, py, py_next;
  logic        coll, coll_next;
  logic [7:0]  wbv, wbv_next;
  logic [3:0]  dgt, dgt_next, dgo, dgo_next;
  logic [63:0] readv, readv_next;
  logic        f_chg, f_chg_next, f_wait, f_wait_next;
  logic        f_unk, f_unk_next, f_abt, f_abt_next;
  res_t        res_q;
  logic        full, full_next;
  logic        load;

  // store ports
  logic [3:0]  ra, rb, rwa;
  logic        rwe;
  logic [7:0]  rwd;
  logic [11:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;
  logic [SW-1:0] stk_addr;
  logic        stk_we;
  logic [11:0] stk_wd;
  logic [4:0]  fr_raddr, fr_waddr;
  logic        fr_we;
  logic [63:0] fr_wd;
  logic        clr_all;

  // decode helpers
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc2, pc4;
  logic [SW-1:0] sp_inc, sp_dec;
  logic        alu_f, alu_flagged;
  logic [7:0]  avx, avy, ares;
  logic [12:0] isum;
  logic [7:0]  ivx;
  logic        kdown, kfound;
  logic [3:0]  kidx;
  logic [1:0]  bh;
  logic [7:0]  brem;
  logic [15:0] bprod;
  logic [3:0]  bt;
  logic [7:0]  bo;
  logic [8:0]  row9;
  logic [63:0] smask, fe;
  logic        sover;
  logic [8:0]  scol;
  logic        skip_take;
  logic [11:0] icnt;

  assign ox  = cur.opcode[11:8];
  assign oy  = cur.opcode[7:4];
  assign on  = cur.opcode[3:0];
  assign kk  = cur.opcode[7:0];
  assign nnn = cur.opcode[11:0];
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;
  assign sp_inc = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign icnt = idx + {8'd0, cnt};

  always_comb begin
    alu_f = 1'b0;
    alu_flagged = 1'b1;
    unique case (on)
      ALU_ADD: alu_f = ({1'b0, rda} + {1'b0, rdb}) > 9'd255;
      ALU_SUB: alu_f = rda > rdb;
      ALU_SHR: alu_f = rda[0];
      ALU_SBN: alu_f = rda < rdb;
      ALU_SHL: alu_f = rda[7];
      default: alu_flagged = 1'b0;
    endcase
    avx = (ox == 4'hF) ? {7'd0, alu_f} : rda;
    avy = (oy == 4'hF) ? {7'd0, alu_f} : rdb;
    case (on)
      ALU_MOV: ares = rdb;
      ALU_OR:  ares = rda | rdb;
      ALU_AND: ares = rda & rdb;
      ALU_XOR: ares = rda ^ rdb;
      ALU_ADD: ares = avx + avy;
      ALU_SUB: ares = avx - avy;
      ALU_SHR: ares = {1'b0, avx[7:1]};
      ALU_SBN: ares = avy - avx;
      ALU_SHL: ares = {avx[6:0], 1'b0};
      default: ares = rda;
    endcase
  end

  assign isum = {5'd0, rda} + {1'b0, idx};
  assign ivx  = (ox == 4'hF) ? {7'd0, isum[12]} : rda;
  assign kdown = (rda < 8'(KEY_COUNT)) && cur.keys_down[rda[3:0]];

  always_comb begin
    kfound = 1'b0;
    kidx = 4'd0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (cur.keys_down[i]) begin
        kfound = 1'b1;
        kidx = 4'(i);
      end
    end
  end

  // bcd digits
  assign bh    = (rda >= 8'd200) ? 2'd2 : ((rda >= 8'd100) ? 2'd1 : 2'd0);
  assign brem  = rda - ((bh == 2'd2) ? 8'd200 : ((bh == 2'd1) ? 8'd100 : 8'd0));
  assign bprod = {8'd0, brem} * 16'd205;
  assign bt    = bprod[14:11];
  assign bo    = brem - ({4'd0, bt} * 8'd10);

  // sprite row placement
  assign row9 = {1'b0, py} + {5'd0, cnt};
  assign fe   = fr_vq ? fr_q : 64'd0;
  always_comb begin
    smask = 64'd0;
    sover = 1'b0;
    scol  = 9'd0;
    for (int c = 0; c < 8; c++) begin
      scol = {1'b0, px} + 9'(c);
      if (mem_q[7-c]) begin
        if (scol < 9'(SCREEN_COLS)) smask[~scol[5:0]] = 1'b1;
        else sover = 1'b1;
      end
    end
  end

  always_comb begin
    case (cur.opcode[15:12])
      GRP_SE:  skip_take = (rda == kk);
      GRP_SNE: skip_take = (rda != kk);
      GRP_SER: skip_take = (rda == rdb);
      default: skip_take = (rda != rdb);
    endcase
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    pc_next = pc;
    idx_next = idx;
    sp_next = sp;
    dly_next = dly;
    snd_next = snd;
    cnt_next = cnt;
    px_next = px;
    py_next = py;
    coll_next = coll;
    wbv_next = wbv;
    dgt_next = dgt;
    dgo_next = dgo;
    readv_next = readv;
    f_chg_next = f_chg;
    f_wait_next = f_wait;
    f_unk_next = f_unk;
    f_abt_next = f_abt;
    load = 1'b0;
    q_pop = 1'b0;
    ra = ox;
    rb = oy;
    rwe = 1'b0;
    rwa = ox;
    rwd = 8'd0;
    mem_addr = cur.address;
    mem_we = 1'b0;
    mem_wd = 8'd0;
    stk_addr = sp;
    stk_we = 1'b0;
    stk_wd = pc;
    fr_raddr = row9[4:0];
    fr_waddr = row9[4:0];
    fr_we = 1'b0;
    fr_wd = fe ^ smask;
    clr_all = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cur_next = q_item;
          ra = (q_item.cls == CL_JPV0) ? 4'd0 : q_item.opcode[11:8];
          rb = q_item.opcode[7:4];
          mem_addr = q_item.address;
          fr_raddr = q_item.address[4:0];
          readv_next = 64'd0;
          f_chg_next = 1'b0;
          f_wait_next = 1'b0;
          f_unk_next = 1'b0;
          f_abt_next = 1'b0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        unique case (cur.cls)
          CL_WRITE: begin
            mem_we = 1'b1;
            mem_wd = cur.write_byte;
          end
          CL_READ: readv_next = {56'd0, mem_q};
          CL_ROW:  readv_next = fr_vq ? fr_q : 64'd0;
          CL_CLS: begin
            clr_all = 1'b1;
            f_chg_next = 1'b1;
            pc_next = pc2;
          end
          CL_RET: begin
            sp_next = sp_dec;
            stk_addr = sp_dec;
            state_next = S_RET;
          end
          CL_JP: pc_next = nnn;
          CL_CALL: begin
            stk_we = 1'b1;
            sp_next = sp_inc;
            pc_next = nnn;
          end
          CL_SKIP: pc_next = skip_take ? pc4 : pc2;
          CL_LOAD: begin
            rwe = 1'b1;
            case (cur.opcode[15:12])
              GRP_LD:  rwd = kk;
              GRP_ADD: rwd = rda + kk;
              default: rwd = cur.random_byte & kk;
            endcase
            pc_next = pc2;
          end
          CL_ALU: begin
            pc_next = pc2;
            if (alu_flagged) begin
              rwe = 1'b1;
              rwa = 4'hF;
              rwd = {7'd0, alu_f};
              wbv_next = ares;
              state_next = S_WB;
            end else if (on == ALU_MOV || on == ALU_OR || on == ALU_AND || on == ALU_XOR) begin
              rwe = 1'b1;
              rwd = ares;
            end else begin
              f_unk_next = 1'b1;
            end
          end
          CL_SETI: begin
            idx_next = nnn;
            pc_next = pc2;
          end
          CL_JPV0: pc_next = nnn + {4'd0, rda};
          CL_DRAW: begin
            px_next = rda;
            py_next = rdb;
            cnt_next = 4'd0;
            coll_next = 1'b0;
            if (on == 4'd0) begin
              rwe = 1'b1;
              rwa = 4'hF;
              rwd = 8'd0;
              f_chg_next = 1'b1;
              pc_next = pc2;
            end else begin
              state_next = S_DRM;
            end
          end
          CL_KEY: begin
            if (kk == KK_SKP) pc_next = kdown ? pc4 : pc2;
            else pc_next = kdown ? pc2 : pc4;
          end
          CL_MISC: begin
            pc_next = pc2;
            unique case (kk)
              KK_LDDT: begin
                rwe = 1'b1;
                rwd = dly;
              end
              KK_WKEY: begin
                if (kfound) begin
                  rwe = 1'b1;
                  rwd = {4'd0, kidx};
                end else begin
                  f_wait_next = 1'b1;
                  pc_next = pc;
                end
              end
              KK_SDT: dly_next = rda;
              KK_SST: snd_next = rda;
              KK_ADDI: begin
                rwe = 1'b1;
                rwa = 4'hF;
                rwd = {7'd0, isum[12]};
                idx_next = idx + {4'd0, ivx};
              end
              KK_FONT: idx_next = {2'd0, rda, 2'd0} + {4'd0, rda};
              KK_BCD: begin
                mem_we = 1'b1;
                mem_addr = idx;
                mem_wd = {6'd0, bh};
                dgt_next = bt;
                dgo_next = bo[3:0];
                pc_next = pc;
                state_next = S_BCD1;
              end
              KK_STR: begin
                cnt_next = 4'd0;
                pc_next = pc;
                state_next = S_STR;
              end
              KK_LDR: begin
                cnt_next = 4'd0;
                pc_next = pc;
                state_next = S_LDR;
              end
              default: begin
                f_unk_next = 1'b1;
                pc_next = pc;
              end
            endcase
          end
          default: f_unk_next = 1'b1;
        endcase
      end
      S_WB: begin
        rwe = 1'b1;
        rwd = wbv;
        state_next = S_FIN;
      end
      S_RET: begin
        pc_next = stk_q + 12'd2;
        state_next = S_FIN;
      end
      S_BCD1: begin
        mem_we = 1'b1;
        mem_addr = idx + 12'd1;
        mem_wd = {4'd0, dgt};
        state_next = S_BCD2;
      end
      S_BCD2: begin
        mem_we = 1'b1;
        mem_addr = idx + 12'd2;
        mem_wd = {4'd0, dgo};
        pc_next = pc2;
        state_next = S_FIN;
      end
      S_STR: begin
        ra = cnt;
        state_next = S_STW;
      end
      S_STW: begin
        mem_we = 1'b1;
        mem_addr = icnt;
        mem_wd = rda;
        if (cnt == ox) begin
          if (bump) idx_next = idx + {8'd0, ox} + 12'd1;
          pc_next = pc2;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 4'd1;
          state_next = S_STR;
        end
      end
      S_LDR: begin
        mem_addr = icnt;
        state_next = S_LDW;
      end
      S_LDW: begin
        rwe = 1'b1;
        rwa = cnt;
        rwd = mem_q;
        if (cnt == ox) begin
          if (bump) idx_next = idx + {8'd0, ox} + 12'd1;
          pc_next = pc2;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 4'd1;
          state_next = S_LDR;
        end
      end
      S_DRM: begin
        mem_addr = icnt;
        fr_raddr = row9[4:0];
        state_next = S_DRR;
      end
      S_DRR: begin
        if (row9 < 9'(SCREEN_ROWS)) begin
          fr_we = 1'b1;
          coll_next = coll | (|(fe & smask));
        end
        if (mem_q != 8'd0 && (row9 >= 9'(SCREEN_ROWS) || sover)) begin
          rwe = 1'b1;
          rwa = 4'hF;
          rwd = {7'd0, coll_next};
          f_abt_next = 1'b1;
          state_next = S_FIN;
        end else if (cnt == on - 4'd1) begin
          rwe = 1'b1;
          rwa = 4'hF;
          rwd = {7'd0, coll_next};
          f_chg_next = 1'b1;
          pc_next = pc2;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 4'd1;
          state_next = S_DRM;
        end
      end
      S_FIN: begin
        if (!full || pop) begin
          load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    full_next = load ? 1'b1 : (full && !pop);
  end

  // register file with reset-valid bits
  always_ff @(posedge clk) begin
    if (rwe) regs[rwa] <= rwd;
    rda <= rvalid[ra] ? regs[ra] : 8'd0;
    rdb <= rvalid[rb] ? regs[rb] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_addr] <= stk_wd;
    stk_q <= stk[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (fr_we) frame[fr_waddr] <= fr_wd;
    fr_q  <= frame[fr_raddr];
    fr_vq <= fvalid[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= '{program_counter: pc, index_value: idx, read_value: readv,
                 display_changed: f_chg, waiting_for_key: f_wait,
                 unknown_opcode: f_unk, draw_aborted: f_abt,
                 sound_active: (snd != 8'd0)};
    end
    cur   <= cur_next;
    cnt   <= cnt_next;
    px    <= px_next;
    py    <= py_next;
    coll  <= coll_next;
    wbv   <= wbv_next;
    dgt   <= dgt_next;
    dgo   <= dgo_next;
    readv <= readv_next;
    f_chg <= f_chg_next;
    f_wait <= f_wait_next;
    f_unk <= f_unk_next;
    f_abt <= f_abt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= PC_RESET;
      idx    <= 12'd0;
      sp     <= '0;
      dly    <= 8'd0;
      snd    <= 8'd0;
      full   <= 1'b0;
      rvalid <= 16'd0;
      fvalid <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      idx   <= idx_next;
      sp    <= sp_next;
      dly   <= dly_next;
      snd   <= snd_next;
      full  <= full_next;
      if (rwe) rvalid[rwa] <= 1'b1;
      if (clr_all) fvalid <= '0;
      else if (fr_we) fvalid[fr_waddr] <= 1'b1;
    end
  end

  assign res   = res_q;
  assign empty = !full;

endmodule

>>> hw/rtl/chip8_instruction_execute.sv
// chip8_instruction_execute: chip-8 execute block, front queue plus back sequencer
// ret, flagged alu ops, bcd, store/load and draw pass through extra sequencer states;
// the back sequencer runs one item at a time and the front queue holds two items;
// the result register frees on pop
// reset (rst, synchronous): pc 512, index, stack pointer, timers, registers and
// display cleared; memory and call stack undefined until written
module chip8_instruction_execute #(
  parameter int STACK_DEPTH = chip8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [15:0] opcode,
  input  logic [11:0] address,
  input  logic [7:0]  write_byte,
  input  logic [15:0] keys_down,
  input  logic [7:0]  random_byte,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] program_counter,
  output logic [11:0] index_value,
  output logic [63:0] read_value,
  output logic        display_changed,
  output logic        waiting_for_key,
  output logic        unknown_opcode,
  output logic        draw_aborted,
  output logic        sound_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import chip8ie_pkg::*;

  item_t q_item;
  res_t  res;
  logic  q_valid, q_pop;
  logic  bump;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bump <= cfg_data;
    end
  end

  chip8ie_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .opcode(opcode), .address(address), .write_byte(write_byte),
    .keys_down(keys_down), .random_byte(random_byte),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  chip8ie_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .bump(bump), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .res(res), .empty(empty), .pop(pop)
  );

  assign program_counter = res.program_counter;
  assign index_value     = res.index_value;
  assign read_value      = res.read_value;
  assign display_changed = res.display_changed;
  assign waiting_for_key = res.waiting_for_key;
  assign unknown_opcode  = res.unknown_opcode;
  assign draw_aborted    = res.draw_aborted;
  assign sound_active    = res.sound_active;

endmodule
